FILE: src/sass_pkg.sv
// Package: payload types, microcode control word and program ROM for the address search.
`timescale 1ns / 1ps
`default_nettype none

package sass_pkg;

  // Field widths fixed by the transaction format
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned INDEX_SPAN = 1 << INDEX_W;

  // Request kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] entry_index;
    logic [ADDR_W-1:0]  entry_address;
    logic [ADDR_W-1:0]  query_address;
  } req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] symbol_index;
    logic               resolved;
  } rsp_t;

  // Microprogram step addresses
  localparam int unsigned STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_WAIT   = 3'd0;
  localparam step_t STEP_CHECK  = 3'd1;
  localparam step_t STEP_FIRST  = 3'd2;
  localparam step_t STEP_LAST   = 3'd3;
  localparam step_t STEP_PROBE  = 3'd4;
  localparam step_t STEP_NARROW = 3'd5;
  localparam step_t STEP_EMIT   = 3'd6;

  // Table read address source
  typedef enum logic [1:0] {
    RD_NONE,
    RD_FIRST,
    RD_LAST,
    RD_MID
  } rd_sel_t;

  // Datapath action
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_START,
    ACT_INIT,
    ACT_PROBE,
    ACT_NARROW,
    ACT_EMIT
  } act_t;

  // Jump condition
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_LOOKUP,
    COND_SHORT,
    COND_BELOW,
    COND_ABOVE,
    COND_DONE,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    rd_sel_t rd_sel;
    act_t    act;
    cond_t   cond;
    logic    hold;          // stay on this step when the condition fails
    logic    miss_on_jump;  // mark the lookup unresolved when the jump is taken
    step_t   target;
  } ctrl_word_t;

  // Microprogram ROM
  function automatic ctrl_word_t ucode_rom(step_t step);
    ctrl_word_t w;
    w = '{rd_sel: RD_NONE, act: ACT_NONE, cond: COND_ALWAYS, hold: 1'b0,
          miss_on_jump: 1'b0, target: STEP_WAIT};
    unique case (step)
      STEP_WAIT: begin
        w.act    = ACT_START;
        w.cond   = COND_LOOKUP;
        w.hold   = 1'b1;
        w.target = STEP_CHECK;
      end
      STEP_CHECK: begin
        w.rd_sel       = RD_FIRST;
        w.cond         = COND_SHORT;
        w.miss_on_jump = 1'b1;
        w.target       = STEP_EMIT;
      end
      STEP_FIRST: begin
        w.rd_sel       = RD_LAST;
        w.cond         = COND_BELOW;
        w.miss_on_jump = 1'b1;
        w.target       = STEP_EMIT;
      end
      STEP_LAST: begin
        w.act          = ACT_INIT;
        w.cond         = COND_ABOVE;
        w.miss_on_jump = 1'b1;
        w.target       = STEP_EMIT;
      end
      STEP_PROBE: begin
        w.rd_sel = RD_MID;
        w.act    = ACT_PROBE;
        w.cond   = COND_DONE;
        w.target = STEP_EMIT;
      end
      STEP_NARROW: begin
        w.act    = ACT_NARROW;
        w.cond   = COND_ALWAYS;
        w.target = STEP_PROBE;
      end
      STEP_EMIT: begin
        w.act    = ACT_EMIT;
        w.cond   = COND_OUT_FREE;
        w.hold   = 1'b1;
        w.target = STEP_WAIT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: src/sorted_address_symbol_search_top.sv
// Top level: sorted address table with microcoded binary floor search.
//
//   channel | handshake             | payload     | direction
//   --------+-----------------------+-------------+----------
//   req     | req_valid / req_stall | req_t req   | in
//   rsp     | rsp_valid / rsp_stall | rsp_t rsp   | out
//   cfg     | cfg_valid / cfg_ready | cfg_data    | in
//
// A write transaction is stored while the sequencer is on its wait step. A lookup over
// n usable entries makes k passes (k at most ceil(log2 n)) through the two-step probe loop
// around the registered table read port before the result register loads; early exits
// skip the loop. The sequencer returns to its wait step as the result loads.
// Reset clears the sequencer, the result valid and entry_count; table contents stay
// undefined until written. A result still stalled when the next one is ready holds the
// sequencer on its emit step, and no new request is taken until it moves on.
`timescale 1ns / 1ps
`default_nettype none

module sorted_address_symbol_search_top
  import sass_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire req_t               req,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output rsp_t                    rsp,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [COUNT_W-1:0] cfg_data
);

  localparam int unsigned MEM_DEPTH = (TABLE_DEPTH < INDEX_SPAN) ? TABLE_DEPTH : INDEX_SPAN;
  localparam int unsigned AW = $clog2(MEM_DEPTH);

  // Sequencer and datapath registers
  step_t              pc, pc_next;
  logic [COUNT_W-1:0] entry_count;
  logic [ADDR_W-1:0]  query;
  logic [COUNT_W-1:0] lo, hi, mid;
  logic               miss;
  logic [ADDR_W-1:0]  rd_data;
  logic [ADDR_W-1:0]  mem [MEM_DEPTH];

  ctrl_word_t         ctrl;
  logic               cond_true;
  logic [COUNT_W-1:0] n;
  logic [COUNT_W-1:0] mid_calc;
  logic [COUNT_W-1:0] rd_index;
  logic               wr_en;
  logic               out_free;
  rsp_t               result;

  assign ctrl      = ucode_rom(pc);
  assign req_stall = (pc != STEP_WAIT);
  assign cfg_ready = 1'b1;
  assign out_free  = !rsp_valid || !rsp_stall;

  // Clamp count to the table span
  assign n        = (entry_count > COUNT_W'(MEM_DEPTH)) ? COUNT_W'(MEM_DEPTH) : entry_count;
  assign mid_calc = COUNT_W'((lo + hi) >> 1);
  assign wr_en    = req_valid && !req_stall && (req.kind == KIND_WRITE) &&
                    (32'(req.entry_index) < TABLE_DEPTH);

  // Evaluate jump condition
  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:    cond_true = 1'b0;
      COND_ALWAYS:   cond_true = 1'b1;
      COND_LOOKUP:   cond_true = req_valid && !req_stall && (req.kind == KIND_LOOKUP);
      COND_SHORT:    cond_true = (n < COUNT_W'(2));
      COND_BELOW:    cond_true = (query < rd_data);
      COND_ABOVE:    cond_true = (query > rd_data);
      COND_DONE:     cond_true = ((hi - lo) <= COUNT_W'(1));
      COND_OUT_FREE: cond_true = out_free;
      default:       cond_true = 1'b0;
    endcase
  end

  // Advance step counter
  always_comb begin
    priority if (cond_true) begin
      pc_next = ctrl.target;
    end else if (ctrl.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + step_t'(1);
    end
  end

  // Select table read index
  always_comb begin
    unique case (ctrl.rd_sel)
      RD_FIRST: rd_index = '0;
      RD_LAST:  rd_index = n - COUNT_W'(1);
      RD_MID:   rd_index = mid_calc;
      default:  rd_index = '0;
    endcase
  end

  // Form the result from the final bound
  always_comb begin
    result = '{symbol_index: lo[INDEX_W-1:0], resolved: 1'b1};
    if (miss || (lo == '0) || (lo == n - COUNT_W'(1))) begin
      result = '{symbol_index: '0, resolved: 1'b0};
    end
  end

  // Table storage with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[req.entry_index[AW-1:0]] <= req.entry_address;
    end
    rd_data <= mem[rd_index[AW-1:0]];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= STEP_WAIT;
      entry_count <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_valid && cfg_ready) begin
        entry_count <= cfg_data;
      end
      if (ctrl.act == ACT_EMIT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cond_true && ctrl.miss_on_jump) begin
      miss <= 1'b1;
    end
    unique case (ctrl.act)
      ACT_START: begin
        query <= req.query_address;
        miss  <= 1'b0;
      end
      ACT_INIT: begin
        lo <= '0;
        hi <= n;
      end
      ACT_PROBE: begin
        mid <= mid_calc;
      end
      ACT_NARROW: begin
        if (rd_data <= query) begin
          lo <= mid;
        end else begin
          hi <= mid;
        end
      end
      ACT_EMIT: begin
        if (out_free) begin
          rsp <= result;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
